// ----- design/gtpg_pkg.sv -----
// Shared types, constants, dimension clamp and pixel formatting functions of the gradient test pattern generator.
package gtpg_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int DIM_W     = 13;
    localparam int LCNT_W    = 17;
    localparam int FMT_W     = 3;
    localparam int PIX_W     = 64;
    localparam int HALF_W    = PIX_W / 2;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_W     = LCNT_W + ROW_W;
    localparam int LVL_W     = NUM_W;
    localparam int REM_W     = $clog2(MAX_HEIGHT + 1);
    localparam int DCNT_W    = $clog2(NUM_W);

    localparam logic [DIM_W-1:0]  WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0]  HEIGHT_RST = DIM_W'(480);
    localparam logic [PIX_W-1:0]  BASE_RST   = '0;
    localparam logic [PIX_W-1:0]  STEP_RST   = PIX_W'(1);
    localparam logic [LCNT_W-1:0] LCNT_RST   = LCNT_W'(256);
    localparam logic [PIX_W-1:0]  LANE_MASK  = 64'h00FF_00FF_00FF_00FF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_BASE   = 3'd2,
        CFG_STEP   = 3'd3,
        CFG_LCNT   = 3'd4,
        CFG_FORMAT = 3'd5
    } t_cfg_idx;

    typedef enum logic [FMT_W-1:0] {
        FMT_8       = 3'd0,
        FMT_16      = 3'd1,
        FMT_16_SWAP = 3'd2,
        FMT_32      = 3'd3,
        FMT_32_SWAP = 3'd4,
        FMT_64      = 3'd5,
        FMT_64_SWAP = 3'd6,
        FMT_64_LANE = 3'd7
    } t_pix_fmt;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NUM,
        S_DIV,
        S_MUL_LO,
        S_MUL_HI,
        S_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic num_load;
        logic div_step;
        logic mul_lo;
        logic mul_hi;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic cache_hit;
        logic div_done;
        logic out_free;
    } t_dp_status;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] reg_val,
                                                 input logic [DIM_W-1:0] max_val);
        logic [DIM_W-1:0] res;
        if (reg_val == '0) begin
            res = DIM_W'(1);
        end else if (reg_val > max_val) begin
            res = max_val;
        end else begin
            res = reg_val;
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] format_pixel(input logic [FMT_W-1:0] fmt,
                                                      input logic [PIX_W-1:0] raw);
        logic [PIX_W-1:0] res;
        logic [PIX_W-1:0] rev;
        for (int b = 0; b < PIX_W / 8; b++) begin
            rev[8*b +: 8] = raw[PIX_W-8-8*b +: 8];
        end
        case (fmt)
            FMT_8:       res = {56'b0, raw[7:0]};
            FMT_16:      res = {48'b0, raw[15:0]};
            FMT_16_SWAP: res = {48'b0, raw[7:0], raw[15:8]};
            FMT_32:      res = {32'b0, raw[31:0]};
            FMT_32_SWAP: res = {32'b0, raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
            FMT_64:      res = raw;
            FMT_64_SWAP: res = rev;
            FMT_64_LANE: res = ((raw >> 8) & LANE_MASK) | ((raw & LANE_MASK) << 8);
            default:     res = raw;
        endcase
        return res;
    endfunction

endpackage

// ----- design/gtpg_ctrl.sv -----
// Controller state machine that sequences the row-level divide and multiply.
module gtpg_ctrl
    import gtpg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_acc;

    assign o_in_ready = (r_state == S_IDLE) && i_status.out_free;
    assign in_acc     = o_in_ready && i_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && !i_status.cache_hit) begin
                    n_state = S_NUM;
                end
            end
            S_NUM:    n_state = S_DIV;
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_FIN;
            S_FIN:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.accept   = in_acc;
        unique case (r_state)
            S_IDLE:   o_cmd.accept   = in_acc;
            S_NUM:    o_cmd.num_load = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_MUL_LO: o_cmd.mul_lo   = 1'b1;
            S_MUL_HI: o_cmd.mul_hi   = 1'b1;
            S_FIN:    o_cmd.finish   = 1'b1;
            default:  o_cmd          = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_fin_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> i_status.out_free)
        else $error("result register still occupied when a computed beat completes");

    a_miss_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_status.cache_hit) |=> (r_state == S_NUM))
        else $error("accepted beat that misses the row cache did not start a computation");
`endif

endmodule

// ----- design/gtpg_dp.sv -----
// Datapath: configuration registers, raster counters, divider, multiplier and result register.
module gtpg_dp
    import gtpg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data,
    input  logic                 i_restart_frame,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PIX_W-1:0]     o_pixel_value,
    output logic                 o_end_of_line,
    output logic                 o_end_of_frame
);

    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [PIX_W-1:0]  r_base;
    logic [PIX_W-1:0]  r_step;
    logic [LCNT_W-1:0] r_lcnt;
    logic [FMT_W-1:0]  r_fmt;

    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  r_item_row;
    logic              r_item_eol;
    logic              r_item_eof;

    logic [NUM_W-1:0]  r_quo;
    logic [REM_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_dcnt;

    logic [LVL_W+HALF_W-1:0] r_prod_lo;
    logic [HALF_W-1:0]       r_prod_hi;
    logic [PIX_W-1:0]        r_acc;

    logic              r_cache_ok;
    logic [ROW_W-1:0]  r_cache_row;
    logic [PIX_W-1:0]  r_cache_pix;

    logic              r_out_valid;
    logic [PIX_W-1:0]  r_pix;
    logic              r_eol;
    logic              r_eof;

    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [COL_W-1:0]  col_eff;
    logic [ROW_W-1:0]  row_eff;
    logic              eol_now;
    logic              eof_now;
    logic              hit;
    logic [REM_W:0]    trial;
    logic              trial_ge;
    logic [LVL_W-1:0]  level;
    logic [PIX_W-1:0]  fin_pix;
    logic              load_out;

    assign w_eff   = eff_dim(r_width, DIM_W'(MAX_WIDTH));
    assign h_eff   = eff_dim(r_height, DIM_W'(MAX_HEIGHT));
    assign col_eff = i_restart_frame ? '0 : r_col;
    assign row_eff = i_restart_frame ? '0 : r_row;
    assign eol_now = DIM_W'(col_eff) >= (w_eff - DIM_W'(1));
    assign eof_now = eol_now && (DIM_W'(row_eff) >= (h_eff - DIM_W'(1)));
    assign hit     = r_cache_ok && (r_cache_row == row_eff);

    assign trial    = {r_rem, r_quo[NUM_W-1]};
    assign trial_ge = trial >= (REM_W+1)'(h_eff);
    assign level    = r_quo[LVL_W-1:0];
    assign fin_pix  = format_pixel(r_fmt, r_acc + {r_prod_hi, {HALF_W{1'b0}}});
    assign load_out = (i_cmd.accept && hit) || i_cmd.finish;

    assign o_status.cache_hit = hit;
    assign o_status.div_done  = r_dcnt == DCNT_W'(NUM_W - 1);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_pixel_value  = r_pix;
    assign o_end_of_line  = r_eol;
    assign o_end_of_frame = r_eof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_base   <= BASE_RST;
            r_step   <= STEP_RST;
            r_lcnt   <= LCNT_RST;
            r_fmt    <= FMT_W'(FMT_8);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                CFG_BASE:   r_base   <= i_cfg_data;
                CFG_STEP:   r_step   <= i_cfg_data;
                CFG_LCNT:   r_lcnt   <= i_cfg_data[LCNT_W-1:0];
                CFG_FORMAT: r_fmt    <= i_cfg_data[FMT_W-1:0];
                default:    r_fmt    <= r_fmt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.accept) begin
            if (eol_now) begin
                r_col <= '0;
                r_row <= eof_now ? '0 : row_eff + ROW_W'(1);
            end else begin
                r_col <= col_eff + COL_W'(1);
                r_row <= row_eff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item_row <= row_eff;
            r_item_eol <= eol_now;
            r_item_eof <= eof_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.num_load) begin
            r_quo  <= NUM_W'(r_lcnt) * NUM_W'(r_item_row);
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[NUM_W-2:0], trial_ge};
            r_rem  <= trial_ge ? REM_W'(trial - (REM_W+1)'(h_eff)) : REM_W'(trial);
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_lo) begin
            r_prod_lo <= (LVL_W+HALF_W)'(level) * (LVL_W+HALF_W)'(r_step[HALF_W-1:0]);
        end
        if (i_cmd.mul_hi) begin
            r_prod_hi <= HALF_W'(level) * r_step[PIX_W-1:HALF_W];
            r_acc     <= PIX_W'(r_prod_lo) + r_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_ok <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_cache_ok <= 1'b0;
        end else if (i_cmd.finish) begin
            r_cache_ok <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_cache_row <= r_item_row;
            r_cache_pix <= fin_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_pix <= fin_pix;
            r_eol <= r_item_eol;
            r_eof <= r_item_eof;
        end else if (i_cmd.accept && hit) begin
            r_pix <= r_cache_pix;
            r_eol <= eol_now;
            r_eof <= eof_now;
        end
    end

`ifndef SYNTHESIS
    a_load_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> o_status.out_free)
        else $error("result register overwritten before its beat was taken");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < REM_W'(h_eff)))
        else $error("divider remainder not below the frame height");
`endif

endmodule

// ----- design/gradient_test_pattern_generator_top.sv -----
// Top level of the vertical gradient test pattern generator.
//
// Each input beat (i_in_valid/o_in_ready) is one pixel tick; i_restart_frame set in a beat
// moves the raster to row 0, column 0 before that pixel. Each input beat yields exactly one
// output beat (o_out_valid/i_out_ready) with the pixel word and end-of-line and end-of-frame
// flags. Registers are written through i_cfg_wr_en/i_cfg_index/i_cfg_data; the user must
// write them only while idle; the block itself does not enforce this. The first pixel
// of a row runs a multiply, a 29-step restoring divide by the frame height and a split
// 29x64 multiply; no new beat is taken until its result is loaded. The row value is then
// held in a one-entry cache: one pixel per clock along a row while the receiver is ready.
// Any configuration write empties the cache. One result register separates the channels:
// a new beat is taken while the previous result is being taken in the same cycle, and a
// stalled receiver holds the result and stops further input.
// Synchronous reset restores the register defaults (640 by 480, 256 levels, step 1,
// base 0, 8-bit format), clears the raster position and empties cache and result register.
module gradient_test_pattern_generator_top
    import gtpg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_restart_frame,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [PIX_W-1:0]     o_pixel_value,
    output logic                 o_end_of_line,
    output logic                 o_end_of_frame
);

    t_dp_cmd    cmd;
    t_dp_status status;

    gtpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gtpg_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_restart_frame (i_restart_frame),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_value   (o_pixel_value),
        .o_end_of_line   (o_end_of_line),
        .o_end_of_frame  (o_end_of_frame)
    );

endmodule
